/* sv/thwd_pkg.sv */
// ----------------------------------------------------------------------------
// thwd_pkg - shared types and constants of the heartbeat watchdog supervisor
// Item and result layouts, operation and stop-reason codes, register indexes
// and the highest-missing-task search.
// ----------------------------------------------------------------------------
package thwd_pkg;

  // Operation codes carried with each input word
  typedef enum logic [1:0] {
    OP_HEARTBEAT = 2'd0,
    OP_CHECK     = 2'd1,
    OP_TICK      = 2'd2
  } op_t;

  // Reason latched by the first stop
  typedef enum logic [1:0] {
    REASON_NONE      = 2'd0,
    REASON_STALL     = 2'd1,
    REASON_HEARTBEAT = 2'd2
  } reason_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PERIOD_RELOAD  = 1'b0,
    CFG_MONITORED_MASK = 1'b1
  } cfg_reg_t;

  localparam int unsigned FLAG_W  = 16;
  localparam int unsigned TASK_W  = 4;
  localparam int unsigned MISS_W  = 5;
  localparam int unsigned STALL_W = 5;
  localparam int unsigned STOP_W  = 3;

  localparam logic [STALL_W-1:0] STALL_LIMIT  = 5'd30;
  localparam logic [STOP_W-1:0]  HALT_COUNT   = 3'd6;
  localparam logic [MISS_W-1:0]  NO_TASK      = 5'd16;
  localparam logic [FLAG_W-1:0]  PERIOD_RESET = 16'd120;
  localparam logic [FLAG_W-1:0]  MASK_RESET   = 16'hFFFF;

  // One accepted input word
  typedef struct packed {
    op_t              op;
    logic [TASK_W-1:0] task_id;
    logic             log_pending;
  } item_t;

  // One result word
  typedef struct packed {
    logic              feed;
    logic              halted;
    logic [MISS_W-1:0] missing_task;
    reason_t           stop_reason;
    logic [FLAG_W-1:0] fault_snapshot;
    logic              log_request;
  } result_t;

  // Highest set bit of v, or NO_TASK when none is set
  function automatic logic [MISS_W-1:0] highest_set(input logic [FLAG_W-1:0] v);
    logic [MISS_W-1:0] r;
    r = NO_TASK;
    for (int i = 0; i < FLAG_W; i++) begin
      if (v[i]) begin
        r = MISS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* sv/task_heartbeat_watchdog_supervisor_core.sv */
// ----------------------------------------------------------------------------
// task_heartbeat_watchdog_supervisor_core - multi-task heartbeat supervisor
// Input stream of heartbeat, tick and check words; one result word each.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per event: s_tuser is the operation (heartbeat,
//   check, tick), s_tdata the reporting task and the log-pending flag.
//   m_* returns exactly one result word per input word, in order: feed,
//   halted, highest missing task, stop reason, fault snapshot, log request.
//   cfg_we/cfg_index/cfg_wdata write the period reload and monitored mask;
//   write them only while no word is in flight.
// Timing:
//   A word sits in the input register while the state update and result
//   are formed, then moves into the output register once that register
//   is free or draining; while it is not, the word waits in the input
//   register. One word per cycle is sustained while m_tready stays high.
// Reset and stall:
//   rst clears both registers' valid flags and restores the supervision
//   state and configuration to their reset values. While m_tready is low
//   the output word holds and the input register still fills, so one more
//   word is taken before s_tready drops.
// ----------------------------------------------------------------------------
module task_heartbeat_watchdog_supervisor_core #(
  parameter int NUM_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] task_id, [4] log_pending, [7:5] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [0] feed, [1] halted, [6:2] missing_task,
                                 // [8:7] stop_reason, [24:9] fault_snapshot,
                                 // [25] log_request, [31:26] zero
);

  logic              in_valid;
  thwd_pkg::item_t   in_item;
  logic              advance;
  thwd_pkg::result_t res;
  thwd_pkg::result_t out_res;

  // Move the held word on when the output register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op          <= thwd_pkg::op_t'(s_tuser);
      in_item.task_id     <= s_tdata[3:0];
      in_item.log_pending <= s_tdata[4];
    end
  end

  thwd_engine #(
    .NUM_TASKS (NUM_TASKS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (in_item),
    .result    (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  // Pack the result word
  assign m_tdata = {6'b0, out_res.log_request, out_res.fault_snapshot,
                    out_res.stop_reason, out_res.missing_task, out_res.halted,
                    out_res.feed};

endmodule

/* sv/thwd_engine.sv */
// ----------------------------------------------------------------------------
// thwd_engine - supervision state and single-pass update
// Holds the flags, period counter, stall and stop counters and fault record,
// works out one item's result combinationally and updates the state on step.
// ----------------------------------------------------------------------------
module thwd_engine #(
  parameter int NUM_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [thwd_pkg::FLAG_W-1:0]    cfg_wdata,
  input  logic                           step,
  input  thwd_pkg::item_t                item,
  output thwd_pkg::result_t              result
);

  localparam int LIMIT = (NUM_TASKS < 16) ? NUM_TASKS : 16;
  localparam logic [thwd_pkg::FLAG_W-1:0] TASK_MASK =
    thwd_pkg::FLAG_W'((33'h1 << LIMIT) - 33'h1);

  logic [thwd_pkg::FLAG_W-1:0]  period_reload;
  logic [thwd_pkg::FLAG_W-1:0]  monitored_mask;
  logic [thwd_pkg::FLAG_W-1:0]  seen_flags, seen_flags_next;
  logic [thwd_pkg::FLAG_W-1:0]  missing_bits, missing_bits_next;
  logic [thwd_pkg::FLAG_W-1:0]  period_left, period_left_next;
  logic [thwd_pkg::STALL_W-1:0] stall_count, stall_count_next;
  logic [thwd_pkg::STOP_W-1:0]  stop_count, stop_count_next;
  thwd_pkg::reason_t            reason_reg, reason_reg_next;
  logic [thwd_pkg::FLAG_W-1:0]  snapshot_reg, snapshot_reg_next;

  logic [thwd_pkg::STOP_W-1:0]  stop_step;
  logic [thwd_pkg::FLAG_W-1:0]  missing_upd;
  logic                         stall_hit;
  logic                         hb_hit;
  logic                         first_stall;
  logic                         first_hb;
  logic                         feed;
  logic [thwd_pkg::MISS_W-1:0]  missing_task;

  // Work out next state and the result for the presented item
  always_comb begin
    seen_flags_next   = seen_flags;
    missing_bits_next = missing_bits;
    period_left_next  = period_left;
    stall_count_next  = stall_count;
    stop_count_next   = stop_count;
    reason_reg_next   = reason_reg;
    snapshot_reg_next = snapshot_reg;
    stop_step         = stop_count;
    missing_upd       = missing_bits & ~seen_flags;
    stall_hit         = 1'b0;
    hb_hit            = 1'b0;
    first_stall       = 1'b0;
    first_hb          = 1'b0;
    feed              = 1'b0;
    missing_task      = thwd_pkg::NO_TASK;

    unique case (item.op)
      thwd_pkg::OP_HEARTBEAT: begin
        if (TASK_MASK[item.task_id]) begin
          seen_flags_next[item.task_id] = 1'b1;
        end
      end
      thwd_pkg::OP_TICK: begin
        if (period_left != '0) begin
          period_left_next = period_left - 1'b1;
        end
      end
      thwd_pkg::OP_CHECK: begin
        // advance a started stop count below the halt value while no log write is outstanding
        if (stop_count != '0 && stop_count < thwd_pkg::HALT_COUNT && !item.log_pending) begin
          stop_step = stop_count + 1'b1;
        end
        stop_count_next = stop_step;
        if (stop_step < thwd_pkg::HALT_COUNT) begin
          // tick-stall test
          if (period_left == period_reload) begin
            if (stall_count >= thwd_pkg::STALL_LIMIT) begin
              stall_hit        = 1'b1;
              stall_count_next = '0;
            end else begin
              stall_count_next = stall_count + 1'b1;
            end
          end else begin
            stall_count_next = '0;
          end
          if (stall_hit && reason_reg == thwd_pkg::REASON_NONE) begin
            first_stall       = 1'b1;
            reason_reg_next   = thwd_pkg::REASON_STALL;
            snapshot_reg_next = missing_bits;
          end

          // clear the seen tasks and report the highest one not seen
          seen_flags_next   = '0;
          missing_bits_next = missing_upd;
          missing_task      = thwd_pkg::highest_set(~seen_flags & TASK_MASK);
          feed              = 1'b1;

          // period expiry
          if (period_left == '0) begin
            hb_hit = (monitored_mask & missing_upd) != '0;
            if (hb_hit && reason_reg_next == thwd_pkg::REASON_NONE) begin
              first_hb          = 1'b1;
              reason_reg_next   = thwd_pkg::REASON_HEARTBEAT;
              snapshot_reg_next = missing_upd;
            end
            period_left_next  = period_reload;
            missing_bits_next = monitored_mask;
          end
          if (stall_hit || hb_hit) begin
            stop_count_next = thwd_pkg::STOP_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    result.feed           = feed;
    result.halted         = stop_count_next >= thwd_pkg::HALT_COUNT;
    result.missing_task   = missing_task;
    result.stop_reason    = reason_reg_next;
    result.fault_snapshot = snapshot_reg_next;
    result.log_request    = first_stall || first_hb;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reload  <= thwd_pkg::PERIOD_RESET;
      monitored_mask <= thwd_pkg::MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thwd_pkg::CFG_PERIOD_RELOAD:  period_reload  <= cfg_wdata;
        thwd_pkg::CFG_MONITORED_MASK: monitored_mask <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Supervision state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flags   <= '0;
      missing_bits <= thwd_pkg::MASK_RESET;
      period_left  <= thwd_pkg::PERIOD_RESET;
      stall_count  <= '0;
      stop_count   <= '0;
      reason_reg   <= thwd_pkg::REASON_NONE;
      snapshot_reg <= '0;
    end else if (step) begin
      seen_flags   <= seen_flags_next;
      missing_bits <= missing_bits_next;
      period_left  <= period_left_next;
      stall_count  <= stall_count_next;
      stop_count   <= stop_count_next;
      reason_reg   <= reason_reg_next;
      snapshot_reg <= snapshot_reg_next;
    end
  end

  // Stall counter is cleared to zero at the limit and never passes it
  a_stall_bound: assert property (@(posedge clk) disable iff (rst)
    stall_count <= thwd_pkg::STALL_LIMIT)
    else $error("stall count beyond limit");

  // Stop count never passes the halt value
  a_stop_bound: assert property (@(posedge clk) disable iff (rst)
    stop_count <= thwd_pkg::HALT_COUNT)
    else $error("stop count beyond halt value");

  // The first stop's reason is never overwritten
  a_reason_sticky: assert property (@(posedge clk) disable iff (rst)
    reason_reg != thwd_pkg::REASON_NONE |=> reason_reg == $past(reason_reg))
    else $error("latched stop reason changed");

  // A log request always comes with a recorded reason
  a_logreq_reason: assert property (@(posedge clk) disable iff (rst)
    result.log_request |-> result.stop_reason != thwd_pkg::REASON_NONE)
    else $error("log request without stop reason");

  // Once halted, the watchdog is not fed
  a_halt_no_feed: assert property (@(posedge clk) disable iff (rst)
    result.halted |-> !result.feed)
    else $error("feed while halted");

endmodule
